[sv/avi_pkg.sv]
// Shared widths, register codes, reset values and the configuration bundle
// for the admittance velocity integrator. No dependencies.
package avi_pkg;

  localparam int FORCE_WIDTH = 24;
  localparam int SPEED_WIDTH = 24;
  localparam int NUM_AXES    = 3;

  localparam int DZ_W     = 23;
  localparam int GAIN_W   = 24;
  localparam int DECAY_W  = 16;
  localparam int SPD_W    = 23;
  localparam int TICK_W   = 16;

  localparam int GAIN_SHIFT  = 18;
  localparam int DECAY_SHIFT = 16;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // Working width of the velocity sum, large enough for every operand.
  localparam int SUM_W = (FORCE_WIDTH + 9 > SPEED_WIDTH + 3) ? FORCE_WIDTH + 9
                                                             : SPEED_WIDTH + 3;

  localparam logic signed [SUM_W-1:0] SPEED_MAX =
    SUM_W'((64'(1) << (SPEED_WIDTH - 1)) - 64'(1));
  localparam logic signed [SUM_W-1:0] SPEED_MIN = -SPEED_MAX - SUM_W'(1);

  localparam logic [DZ_W-1:0]    RST_DEADZONE  = DZ_W'(1180);
  localparam logic [GAIN_W-1:0]  RST_GAIN      = GAIN_W'(16777);
  localparam logic [DECAY_W-1:0] RST_DECAY     = DECAY_W'(2621);
  localparam logic [SPD_W-1:0]   RST_MAX_SPEED = SPD_W'(335544);
  localparam logic [SPD_W-1:0]   RST_EPSILON   = SPD_W'(2097);
  localparam logic [TICK_W-1:0]  RST_TIMEOUT   = TICK_W'(30);

  typedef enum logic [0:0] {
    CMD_FORCE = 1'b0,
    CMD_TICK  = 1'b1
  } avi_cmd_e;

  typedef enum logic [2:0] {
    REG_DEADZONE  = 3'd0,
    REG_GAIN_X    = 3'd1,
    REG_GAIN_Y    = 3'd2,
    REG_GAIN_Z    = 3'd3,
    REG_DECAY     = 3'd4,
    REG_MAX_SPEED = 3'd5,
    REG_EPSILON   = 3'd6,
    REG_TIMEOUT   = 3'd7
  } avi_reg_e;

  typedef struct packed {
    logic [DZ_W-1:0]                  deadzone;
    logic [NUM_AXES-1:0][GAIN_W-1:0]  gain;
    logic [DECAY_W-1:0]               decay;
    logic [SPD_W-1:0]                 max_speed;
    logic [SPD_W-1:0]                 speed_epsilon;
    logic [TICK_W-1:0]                timeout_ticks;
  } avi_cfg_t;

endpackage

[sv/admittance_velocity_integrator.sv]
// Three-axis admittance velocity integrator, top level.
// A tick beat goes through the input register, then one pass of per-axis
// arithmetic into the result register.
// Throughput: one beat per cycle unless a stalled result holds back a tick.
// Reset: asynchronous, active low; targets, velocities and the tick counter
// clear to zero and the registers take their default values.
module admittance_velocity_integrator (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [avi_pkg::APB_AW-1:0]             paddr,
  input  logic [avi_pkg::APB_DW-1:0]             pwdata,
  output logic [avi_pkg::APB_DW-1:0]             prdata,
  output logic                                   pready,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   command_i,
  input  logic signed [avi_pkg::FORCE_WIDTH-1:0] force_x_i,
  input  logic signed [avi_pkg::FORCE_WIDTH-1:0] force_y_i,
  input  logic signed [avi_pkg::FORCE_WIDTH-1:0] force_z_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [avi_pkg::SPEED_WIDTH-1:0] vel_x_o,
  output logic signed [avi_pkg::SPEED_WIDTH-1:0] vel_y_o,
  output logic signed [avi_pkg::SPEED_WIDTH-1:0] vel_z_o,
  output logic                                   stale_o
);

  localparam int FW = avi_pkg::FORCE_WIDTH;
  localparam int SW = avi_pkg::SPEED_WIDTH;
  localparam int NA = avi_pkg::NUM_AXES;
  localparam int TW = avi_pkg::TICK_W;

  avi_pkg::avi_cfg_t cfg;

  avi_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register stage.
  logic                 s1_valid_q;
  avi_pkg::avi_cmd_e    s1_cmd_q;
  logic signed [FW-1:0] s1_force_q [NA];

  // Block state.
  logic signed [FW-1:0] target_q [NA];
  logic signed [SW-1:0] vel_q    [NA];
  logic signed [SW-1:0] vel_d    [NA];
  logic [TW-1:0]        ticks_q, ticks_inc;
  logic                 stale;

  // Result register.
  logic                 out_valid_q;
  logic signed [SW-1:0] out_vel_q [NA];
  logic                 out_stale_q;

  logic out_free, s1_adv, s1_load, tick_go, force_go;

  // A force beat never needs the result register, so it leaves at once.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && ((s1_cmd_q == avi_pkg::CMD_FORCE) || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign s1_load    = in_valid_i && !in_stall_o;
  assign tick_go    = s1_adv && (s1_cmd_q == avi_pkg::CMD_TICK);
  assign force_go   = s1_adv && (s1_cmd_q == avi_pkg::CMD_FORCE);

  assign ticks_inc = (ticks_q == {TW{1'b1}}) ? ticks_q : ticks_q + TW'(1);
  assign stale     = ticks_inc > cfg.timeout_ticks;

  for (genvar a = 0; a < NA; a++) begin : g_axis
    avi_axis u_axis (
      .target_i (target_q[a]),
      .vel_i    (vel_q[a]),
      .gain_i   (cfg.gain[a]),
      .cfg_i    (cfg),
      .stale_i  (stale),
      .vel_o    (vel_d[a])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ticks_q     <= '0;
      for (int a = 0; a < NA; a++) begin
        target_q[a] <= '0;
        vel_q[a]    <= '0;
      end
    end else begin
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (tick_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (force_go) begin
        ticks_q <= '0;
        for (int a = 0; a < NA; a++) begin
          target_q[a] <= s1_force_q[a];
        end
      end else if (tick_go) begin
        ticks_q <= ticks_inc;
        for (int a = 0; a < NA; a++) begin
          vel_q[a] <= vel_d[a];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_cmd_q      <= avi_pkg::avi_cmd_e'(command_i);
      s1_force_q[0] <= force_x_i;
      s1_force_q[1] <= force_y_i;
      s1_force_q[2] <= force_z_i;
    end
    if (tick_go) begin
      out_stale_q <= stale;
      for (int a = 0; a < NA; a++) begin
        out_vel_q[a] <= vel_d[a];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign vel_x_o     = out_vel_q[0];
  assign vel_y_o     = out_vel_q[1];
  assign vel_z_o     = out_vel_q[2];
  assign stale_o     = out_stale_q;

  // A pending result always mirrors the stored velocity state.
  a_out_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (vel_x_o == vel_q[0]) && (vel_y_o == vel_q[1]) &&
                    (vel_z_o == vel_q[2]))
    else $error("result beat differs from velocity state");

  // A force beat restarts the staleness counter.
  a_force_clears_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    force_go |=> (ticks_q == '0))
    else $error("tick counter not cleared by force beat");

  // An empty input stage never holds off the producer.
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("stall raised with empty input stage");

endmodule

[sv/avi_regs.sv]
// APB-style configuration register file for the admittance integrator.
// Depends on avi_pkg.
module avi_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [avi_pkg::APB_AW-1:0]  paddr,
  input  logic [avi_pkg::APB_DW-1:0]  pwdata,
  output logic [avi_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output avi_pkg::avi_cfg_t           cfg_o
);

  avi_pkg::avi_cfg_t cfg_q, cfg_d;
  avi_pkg::avi_reg_e idx;
  logic              wr_en;

  assign idx    = avi_pkg::avi_reg_e'(paddr[avi_pkg::APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        avi_pkg::REG_DEADZONE:  cfg_d.deadzone      = pwdata[avi_pkg::DZ_W-1:0];
        avi_pkg::REG_GAIN_X:    cfg_d.gain[0]       = pwdata[avi_pkg::GAIN_W-1:0];
        avi_pkg::REG_GAIN_Y:    cfg_d.gain[1]       = pwdata[avi_pkg::GAIN_W-1:0];
        avi_pkg::REG_GAIN_Z:    cfg_d.gain[2]       = pwdata[avi_pkg::GAIN_W-1:0];
        avi_pkg::REG_DECAY:     cfg_d.decay         = pwdata[avi_pkg::DECAY_W-1:0];
        avi_pkg::REG_MAX_SPEED: cfg_d.max_speed     = pwdata[avi_pkg::SPD_W-1:0];
        avi_pkg::REG_EPSILON:   cfg_d.speed_epsilon = pwdata[avi_pkg::SPD_W-1:0];
        avi_pkg::REG_TIMEOUT:   cfg_d.timeout_ticks = pwdata[avi_pkg::TICK_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      avi_pkg::REG_DEADZONE:  prdata = avi_pkg::APB_DW'(cfg_q.deadzone);
      avi_pkg::REG_GAIN_X:    prdata = avi_pkg::APB_DW'(cfg_q.gain[0]);
      avi_pkg::REG_GAIN_Y:    prdata = avi_pkg::APB_DW'(cfg_q.gain[1]);
      avi_pkg::REG_GAIN_Z:    prdata = avi_pkg::APB_DW'(cfg_q.gain[2]);
      avi_pkg::REG_DECAY:     prdata = avi_pkg::APB_DW'(cfg_q.decay);
      avi_pkg::REG_MAX_SPEED: prdata = avi_pkg::APB_DW'(cfg_q.max_speed);
      avi_pkg::REG_EPSILON:   prdata = avi_pkg::APB_DW'(cfg_q.speed_epsilon);
      avi_pkg::REG_TIMEOUT:   prdata = avi_pkg::APB_DW'(cfg_q.timeout_ticks);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadzone      <= avi_pkg::RST_DEADZONE;
      cfg_q.gain          <= {avi_pkg::NUM_AXES{avi_pkg::RST_GAIN}};
      cfg_q.decay         <= avi_pkg::RST_DECAY;
      cfg_q.max_speed     <= avi_pkg::RST_MAX_SPEED;
      cfg_q.speed_epsilon <= avi_pkg::RST_EPSILON;
      cfg_q.timeout_ticks <= avi_pkg::RST_TIMEOUT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[sv/avi_axis.sv]
// One axis of the velocity update: deadband, gain and decay products,
// clamping and the small-speed cut. Depends on avi_pkg.
module avi_axis (
  input  logic signed [avi_pkg::FORCE_WIDTH-1:0] target_i,
  input  logic signed [avi_pkg::SPEED_WIDTH-1:0] vel_i,
  input  logic        [avi_pkg::GAIN_W-1:0]      gain_i,
  input  avi_pkg::avi_cfg_t                      cfg_i,
  input  logic                                   stale_i,
  output logic signed [avi_pkg::SPEED_WIDTH-1:0] vel_o
);

  localparam int FW = avi_pkg::FORCE_WIDTH;
  localparam int SW = avi_pkg::SPEED_WIDTH;
  localparam int MW = (FW > avi_pkg::DZ_W) ? FW : avi_pkg::DZ_W;
  localparam int PW = FW + avi_pkg::GAIN_W + 1;
  localparam int DW = SW + avi_pkg::DECAY_W + 1;
  localparam int SUM_W = avi_pkg::SUM_W;

  logic signed [FW-1:0]    f, fe, dz_f;
  logic        [FW-1:0]    mag;
  logic signed [PW-1:0]    gprod;
  logic signed [DW-1:0]    dprod;
  logic signed [SUM_W-1:0] sum, ms, eps, c1, c2, mag_v;

  assign f    = stale_i ? '0 : target_i;
  assign mag  = f[FW-1] ? FW'(-f) : FW'(f);
  // Only used when the magnitude exceeds the deadzone, so it then fits.
  assign dz_f = $signed(FW'(cfg_i.deadzone));

  always_comb begin
    if (MW'(mag) <= MW'(cfg_i.deadzone)) begin
      fe = '0;
    end else if (f[FW-1]) begin
      fe = f + dz_f;
    end else begin
      fe = f - dz_f;
    end
  end

  assign gprod = PW'(fe) * PW'($signed({1'b0, gain_i}));
  assign dprod = DW'(vel_i) * DW'($signed({1'b0, cfg_i.decay}));

  // Arithmetic right shifts give the floor of each product.
  assign sum = SUM_W'(vel_i) + SUM_W'(gprod >>> avi_pkg::GAIN_SHIFT)
             - SUM_W'(dprod >>> avi_pkg::DECAY_SHIFT);

  assign ms  = $signed(SUM_W'(cfg_i.max_speed));
  assign eps = $signed(SUM_W'(cfg_i.speed_epsilon));

  always_comb begin
    priority if (sum > ms) begin
      c1 = ms;
    end else if (sum < -ms) begin
      c1 = -ms;
    end else begin
      c1 = sum;
    end
    priority if (c1 > avi_pkg::SPEED_MAX) begin
      c2 = avi_pkg::SPEED_MAX;
    end else if (c1 < avi_pkg::SPEED_MIN) begin
      c2 = avi_pkg::SPEED_MIN;
    end else begin
      c2 = c1;
    end
  end

  assign mag_v = c2[SUM_W-1] ? -c2 : c2;
  assign vel_o = (mag_v < eps) ? '0 : SW'(c2);

endmodule
